// File: sv/hcme_pkg.sv
package hcme_pkg;

  // Build-time defaults for the top-level parameters.
  localparam int MAX_WIDTH_DEF    = 1024;
  localparam int ERODE_PASSES_DEF = 2;

  // Fixed geometry of the block.
  localparam int RING_ROWS    = 8;
  localparam int RING_BITS    = 3;
  localparam int HEIGHT_LIMIT = 1024;
  localparam int HEIGHT_W     = 11;
  localparam int ROW_W        = 10;
  localparam int CFG_W        = 11;
  localparam int W_RESET      = 640;
  localparam int H_RESET      = 480;

  // Window taps for the largest supported radius (two passes give five columns).
  localparam int WIN_MAX = 5;

  // Result queue between the front and the back.
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = 2;
  localparam int QCNT_W      = 3;

  // Configuration register indexes.
  typedef enum logic [0:0] {
    CFG_LINE_WIDTH   = 1'b0,
    CFG_FRAME_HEIGHT = 1'b1
  } cfg_index_e;

  // Position recalculation sequence after a geometry write.
  typedef enum logic [1:0] {
    CALC_IDLE,
    CALC_MUL,
    CALC_SUM
  } calc_state_e;

  // One inclusive HSV box.
  typedef struct packed {
    logic [7:0] h_lo;
    logic [7:0] h_hi;
    logic [7:0] s_lo;
    logic [7:0] s_hi;
    logic [7:0] v_lo;
    logic [7:0] v_hi;
  } color_box_t;

  localparam int NUM_BOXES = 5;

  // Green high, green low, red high, red low and white.
  localparam color_box_t BOXES [NUM_BOXES] = '{
    '{h_lo: 8'd75, h_hi: 8'd105, s_lo: 8'd20,  s_hi: 8'd125, v_lo: 8'd235, v_hi: 8'd255},
    '{h_lo: 8'd60, h_hi: 8'd85,  s_lo: 8'd120, s_hi: 8'd185, v_lo: 8'd210, v_hi: 8'd255},
    '{h_lo: 8'd50, h_hi: 8'd195, s_lo: 8'd60,  s_hi: 8'd125, v_lo: 8'd215, v_hi: 8'd255},
    '{h_lo: 8'd0,  h_hi: 8'd10,  s_lo: 8'd50,  s_hi: 8'd125, v_lo: 8'd220, v_hi: 8'd255},
    '{h_lo: 8'd0,  h_hi: 8'd5,   s_lo: 8'd0,   s_hi: 8'd5,   v_lo: 8'd230, v_hi: 8'd255}
  };

  // Window description handed from the front to the back.
  typedef struct packed {
    logic                 eor;
    logic                 eof;
    logic [RING_ROWS-1:0] row_mask;
    logic [WIN_MAX-1:0]   col_mask;
  } job_meta_t;

  // One queue entry: window description plus one column word per tap.
  typedef struct packed {
    job_meta_t                          meta;
    logic [WIN_MAX-1:0][RING_ROWS-1:0]  words;
  } win_entry_t;

  // Mask bit of one pixel: set when it falls inside any of the boxes.
  function automatic logic classify(input logic [7:0] h, input logic [7:0] s,
                                    input logic [7:0] v);
    logic hit;
    hit = 1'b0;
    for (int b = 0; b < NUM_BOXES; b++) begin
      if (h >= BOXES[b].h_lo && h <= BOXES[b].h_hi &&
          s >= BOXES[b].s_lo && s <= BOXES[b].s_hi &&
          v >= BOXES[b].v_lo && v <= BOXES[b].v_hi) begin
        hit = 1'b1;
      end
    end
    return hit;
  endfunction

endpackage

// File: sv/hcme_line_store.sv
module hcme_line_store
  import hcme_pkg::*;
#(
  parameter int MAX_WIDTH    = MAX_WIDTH_DEF,
  parameter int ERODE_PASSES = ERODE_PASSES_DEF,
  localparam int CW          = $clog2(MAX_WIDTH)
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               wr_en_i,
  input  logic [CW-1:0]                      wr_col_i,
  input  logic [RING_BITS-1:0]               wr_row_i,
  input  logic                               wr_bit_i,
  input  logic                               rd_en_i,
  input  logic [WIN_MAX-1:0][CW-1:0]         rd_col_i,
  output logic [WIN_MAX-1:0][RING_ROWS-1:0]  words_o
);

  localparam int TAPS = 2 * ERODE_PASSES + 1;

  // A write at the same edge as a read of its column is merged into its data.
  logic                 byp_en_q;
  logic [CW-1:0]        byp_col_q;
  logic [RING_BITS-1:0] byp_row_q;
  logic                 byp_bit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byp_en_q <= 1'b0;
    end else begin
      byp_en_q <= wr_en_i & rd_en_i;
    end
  end

  always_ff @(posedge clk_i) begin
    byp_col_q <= wr_col_i;
    byp_row_q <= wr_row_i;
    byp_bit_q <= wr_bit_i;
  end

  // One bank per window tap; every bank stores the full ring, one column per word.
  for (genvar k = 0; k < WIN_MAX; k++) begin : g_tap
    if (k < TAPS) begin : g_bank
      logic [RING_ROWS-1:0] mem_q [MAX_WIDTH];
      logic [RING_ROWS-1:0] rd_q;
      logic [CW-1:0]        rd_col_q;

      always_ff @(posedge clk_i) begin
        if (wr_en_i) begin
          mem_q[wr_col_i][wr_row_i] <= wr_bit_i;
        end
        if (rd_en_i) begin
          rd_q     <= mem_q[rd_col_i[k]];
          rd_col_q <= rd_col_i[k];
        end
      end

      always_comb begin
        words_o[k] = rd_q;
        if (byp_en_q && (byp_col_q == rd_col_q)) begin
          words_o[k][byp_row_q] = byp_bit_q;
        end
      end
    end else begin : g_unused
      assign words_o[k] = '1;
    end
  end

endmodule

// File: sv/hcme_front.sv
module hcme_front
  import hcme_pkg::*;
#(
  parameter int MAX_WIDTH    = MAX_WIDTH_DEF,
  parameter int ERODE_PASSES = ERODE_PASSES_DEF,
  localparam int CW          = $clog2(MAX_WIDTH)
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [7:0]                  hue_i,
  input  logic [7:0]                  saturation_i,
  input  logic [7:0]                  brightness_i,
  input  logic                        is_flush_i,
  input  logic                        cfg_we_i,
  input  logic [0:0]                  cfg_index_i,
  input  logic [CFG_W-1:0]            cfg_wdata_i,
  input  logic [QCNT_W-1:0]           q_count_i,
  output logic                        wr_en_o,
  output logic [CW-1:0]               wr_col_o,
  output logic [RING_BITS-1:0]        wr_row_o,
  output logic                        wr_bit_o,
  output logic                        rd_en_o,
  output logic [WIN_MAX-1:0][CW-1:0]  rd_col_o,
  output logic                        job_valid_o,
  output job_meta_t                   job_meta_o
);

  localparam int WW      = CW + 1;
  localparam int PW      = ROW_W + CW + 2;
  localparam int TAPS    = 2 * ERODE_PASSES + 1;
  localparam int W_RST   = (W_RESET > MAX_WIDTH) ? MAX_WIDTH : W_RESET;
  localparam int LAG_RST = ERODE_PASSES * W_RST + ERODE_PASSES;

  // Geometry, as clamped at write time.
  logic [WW-1:0]       used_w_q, used_w_d;
  logic [HEIGHT_W-1:0] used_h_q, used_h_d;

  // Raster counters and linear positions.
  logic [CW-1:0]    in_col_q, in_col_d, out_col_q, out_col_d;
  logic [ROW_W-1:0] in_row_q, in_row_d, out_row_q, out_row_d;
  logic [PW-1:0]    in_pos_q, in_pos_d, out_base_q, out_base_d, lag_q, lag_d;
  logic [PW-1:0]    in_prod_q, in_prod_d, out_prod_q, out_prod_d;
  logic             draining_q, draining_d;

  calc_state_e calc_q, calc_d;
  logic        calc_busy, calc_mul, calc_sum;

  logic job_valid_q;
  job_meta_t job_meta_q, meta_d;

  logic [WW-1:0]       wm1;
  logic [HEIGHT_W-1:0] hm1;
  logic accept, pixel, pos_ready, emit, frame_done;
  logic in_col_wrap, in_row_wrap, out_eor, out_eof;
  logic [ROW_W+WW-1:0] in_mul, out_mul;

  // Configuration writes store the geometry already clamped.
  always_comb begin
    used_w_d = used_w_q;
    used_h_d = used_h_q;
    if (cfg_we_i) begin
      case (cfg_index_e'(cfg_index_i))
        CFG_LINE_WIDTH: begin
          if (cfg_wdata_i == '0) begin
            used_w_d = WW'(1);
          end else if (32'(cfg_wdata_i) > MAX_WIDTH) begin
            used_w_d = WW'(MAX_WIDTH);
          end else begin
            used_w_d = WW'(cfg_wdata_i);
          end
        end
        CFG_FRAME_HEIGHT: begin
          if (cfg_wdata_i == '0) begin
            used_h_d = HEIGHT_W'(1);
          end else if (32'(cfg_wdata_i) > HEIGHT_LIMIT) begin
            used_h_d = HEIGHT_W'(HEIGHT_LIMIT);
          end else begin
            used_h_d = cfg_wdata_i;
          end
        end
        default: begin
          used_w_d = used_w_q;
        end
      endcase
    end
  end

  // Recalculation sequence: next state.
  always_comb begin
    case (calc_q)
      CALC_IDLE: calc_d = CALC_IDLE;
      CALC_MUL:  calc_d = CALC_SUM;
      CALC_SUM:  calc_d = CALC_IDLE;
      default:   calc_d = CALC_IDLE;
    endcase
    if (cfg_we_i) begin
      calc_d = CALC_MUL;
    end
  end

  // Recalculation sequence: outputs.
  always_comb begin
    calc_busy = 1'b1;
    calc_mul  = 1'b0;
    calc_sum  = 1'b0;
    case (calc_q)
      CALC_IDLE: calc_busy = 1'b0;
      CALC_MUL:  calc_mul  = 1'b1;
      CALC_SUM:  calc_sum  = 1'b1;
      default:   calc_busy = 1'b1;
    endcase
  end

  // Accept only when the queue has room for every result still in flight.
  assign in_ready_o = ~calc_busy & ~cfg_we_i &
                      (({1'b0, q_count_i} + (QCNT_W+1)'(job_valid_q)) <
                       (QCNT_W+1)'(QUEUE_DEPTH));
  assign accept = in_valid_i & in_ready_o;

  // Item classification against the current counters.
  assign wm1         = used_w_q - WW'(1);
  assign hm1         = used_h_q - HEIGHT_W'(1);
  assign pixel       = ~is_flush_i & ~draining_q;
  assign in_col_wrap = {1'b0, in_col_q} >= wm1;
  assign in_row_wrap = {1'b0, in_row_q} >= hm1;
  assign frame_done  = pixel & in_col_wrap & in_row_wrap;
  assign pos_ready   = in_pos_q >= (out_base_q + lag_q);
  assign emit        = pixel ? pos_ready : draining_q;
  assign out_eor     = {1'b0, out_col_q} >= wm1;
  assign out_eof     = out_eor & ({1'b0, out_row_q} >= hm1);

  assign in_mul  = in_row_q * used_w_q;
  assign out_mul = out_row_q * used_w_q;

  // Counter, position and drain updates.
  always_comb begin
    in_col_d   = in_col_q;
    in_row_d   = in_row_q;
    in_pos_d   = in_pos_q;
    out_col_d  = out_col_q;
    out_row_d  = out_row_q;
    out_base_d = out_base_q;
    lag_d      = lag_q;
    in_prod_d  = in_prod_q;
    out_prod_d = out_prod_q;
    draining_d = draining_q;
    if (calc_mul) begin
      in_prod_d  = PW'(in_mul);
      out_prod_d = PW'(out_mul);
    end
    if (calc_sum) begin
      in_pos_d   = in_prod_q + PW'(in_col_q);
      out_base_d = out_prod_q + PW'(out_col_q);
      lag_d      = PW'(ERODE_PASSES) * PW'(used_w_q) + PW'(ERODE_PASSES);
    end
    if (accept) begin
      if (pixel) begin
        if (in_col_wrap) begin
          in_col_d = '0;
          if (in_row_wrap) begin
            in_row_d = '0;
            in_pos_d = '0;
          end else begin
            in_row_d = in_row_q + ROW_W'(1);
            in_pos_d = in_pos_q - PW'(in_col_q) + PW'(used_w_q);
          end
        end else begin
          in_col_d = in_col_q + CW'(1);
          in_pos_d = in_pos_q + PW'(1);
        end
      end
      if (emit) begin
        if (out_eof) begin
          out_col_d  = '0;
          out_row_d  = '0;
          out_base_d = '0;
        end else if (out_eor) begin
          out_col_d  = '0;
          out_row_d  = out_row_q + ROW_W'(1);
          out_base_d = out_base_q - PW'(out_col_q) + PW'(used_w_q);
        end else begin
          out_col_d  = out_col_q + CW'(1);
          out_base_d = out_base_q + PW'(1);
        end
      end
      if (frame_done) begin
        draining_d = 1'b1;
      end else if (emit && out_eof) begin
        draining_d = 1'b0;
      end
    end
  end

  // Window around the output position, clipped at the frame edges.
  always_comb begin
    logic [ROW_W+1:0] rsum;
    logic [CW+1:0]    csum;
    meta_d          = '0;
    meta_d.eor      = out_eor;
    meta_d.eof      = out_eof;
    rd_col_o        = '0;
    for (int d = 0; d < WIN_MAX; d++) begin
      rsum = {2'b0, out_row_q} + (ROW_W+2)'(d);
      csum = {2'b0, out_col_q} + (CW+2)'(d);
      if (d < TAPS) begin
        if (rsum >= (ROW_W+2)'(ERODE_PASSES) &&
            rsum < ((ROW_W+2)'(used_h_q) + (ROW_W+2)'(ERODE_PASSES))) begin
          meta_d.row_mask[RING_BITS'(rsum - (ROW_W+2)'(ERODE_PASSES))] = 1'b1;
        end
        if (csum >= (CW+2)'(ERODE_PASSES) &&
            csum < ((CW+2)'(used_w_q) + (CW+2)'(ERODE_PASSES))) begin
          meta_d.col_mask[d] = 1'b1;
          rd_col_o[d]        = CW'(csum - (CW+2)'(ERODE_PASSES));
        end
      end
    end
  end

  // Line store accesses for the accepted item.
  assign wr_en_o  = accept & pixel;
  assign wr_col_o = in_col_q;
  assign wr_row_o = in_row_q[RING_BITS-1:0];
  assign wr_bit_o = classify(hue_i, saturation_i, brightness_i);
  assign rd_en_o  = accept & emit;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_w_q    <= WW'(W_RST);
      used_h_q    <= HEIGHT_W'(H_RESET);
      in_col_q    <= '0;
      in_row_q    <= '0;
      out_col_q   <= '0;
      out_row_q   <= '0;
      in_pos_q    <= '0;
      out_base_q  <= '0;
      lag_q       <= PW'(LAG_RST);
      draining_q  <= 1'b0;
      calc_q      <= CALC_IDLE;
      job_valid_q <= 1'b0;
    end else begin
      used_w_q    <= used_w_d;
      used_h_q    <= used_h_d;
      in_col_q    <= in_col_d;
      in_row_q    <= in_row_d;
      out_col_q   <= out_col_d;
      out_row_q   <= out_row_d;
      in_pos_q    <= in_pos_d;
      out_base_q  <= out_base_d;
      lag_q       <= lag_d;
      draining_q  <= draining_d;
      calc_q      <= calc_d;
      job_valid_q <= accept & emit;
    end
  end

  // Products and window description carry no reset.
  always_ff @(posedge clk_i) begin
    in_prod_q  <= in_prod_d;
    out_prod_q <= out_prod_d;
    if (accept && emit) begin
      job_meta_q <= meta_d;
    end
  end

  assign job_valid_o = job_valid_q;
  assign job_meta_o  = job_meta_q;

endmodule

// File: sv/hcme_fifo.sv
module hcme_fifo
  import hcme_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  win_entry_t        push_data_i,
  input  logic              pop_i,
  output win_entry_t        pop_data_o,
  output logic [QCNT_W-1:0] count_o
);

  win_entry_t          slot_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr_q, rd_ptr_q;
  logic [QCNT_W-1:0]   count_q;

  // Pointers and fill count; the front never pushes into a full queue.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
      end
      count_q <= count_q + QCNT_W'(push_i) - QCNT_W'(pop_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= push_data_i;
    end
  end

  assign pop_data_o = slot_q[rd_ptr_q];
  assign count_o    = count_q;

endmodule

// File: sv/hcme_back.sv
module hcme_back
  import hcme_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [QCNT_W-1:0] q_count_i,
  input  win_entry_t        entry_i,
  output logic              pop_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic              mask_bit_o,
  output logic              end_of_row_o,
  output logic              end_of_frame_o
);

  logic out_valid_q;
  logic mask_q, eor_q, eof_q;
  logic win_min;

  // Take the next window when the output register is free or being emptied.
  assign pop_o = (q_count_i != '0) & (~out_valid_q | out_ready_i);

  // Minimum over the window: any cleared bit inside both masks clears the result.
  always_comb begin
    win_min = 1'b1;
    for (int k = 0; k < WIN_MAX; k++) begin
      for (int r = 0; r < RING_ROWS; r++) begin
        if (entry_i.meta.col_mask[k] && entry_i.meta.row_mask[r] && !entry_i.words[k][r]) begin
          win_min = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (pop_o) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      mask_q <= win_min;
      eor_q  <= entry_i.meta.eor;
      eof_q  <= entry_i.meta.eof;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign mask_bit_o     = mask_q;
  assign end_of_row_o   = eor_q;
  assign end_of_frame_o = eof_q;

endmodule

// File: sv/hsv_color_mask_erode_top.sv
// A word that completes a window is registered, queued and popped into the output register.
// Output pixels trail the input by ERODE_PASSES rows plus ERODE_PASSES columns of the frame.
// Throughput: one word per cycle, set by the single accept stage and one line store access,
// while in_ready_o is high; a configuration write and its position recalculation drop it.
// Reset clears counters and the drain flag and restores 640 x 480 geometry (width at most
// MAX_WIDTH); the line store is not cleared and holds whatever it held until written.
module hsv_color_mask_erode_top
  import hcme_pkg::*;
#(
  parameter int MAX_WIDTH    = MAX_WIDTH_DEF,
  parameter int ERODE_PASSES = ERODE_PASSES_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [7:0]       hue_i,
  input  logic [7:0]       saturation_i,
  input  logic [7:0]       brightness_i,
  input  logic             is_flush_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic             mask_bit_o,
  output logic             end_of_row_o,
  output logic             end_of_frame_o,
  input  logic             cfg_we_i,
  input  logic [0:0]       cfg_index_i,
  input  logic [CFG_W-1:0] cfg_wdata_i
);

  localparam int CW = $clog2(MAX_WIDTH);

  logic                              wr_en, wr_bit, rd_en, job_valid, pop;
  logic [CW-1:0]                     wr_col;
  logic [RING_BITS-1:0]              wr_row;
  logic [WIN_MAX-1:0][CW-1:0]        rd_col;
  logic [WIN_MAX-1:0][RING_ROWS-1:0] words;
  logic [QCNT_W-1:0]                 q_count;
  job_meta_t                         job_meta;
  win_entry_t                        push_entry, head_entry;

  // Front: accepts words, classifies pixels and tracks the raster.
  hcme_front #(
    .MAX_WIDTH   (MAX_WIDTH),
    .ERODE_PASSES(ERODE_PASSES)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .hue_i       (hue_i),
    .saturation_i(saturation_i),
    .brightness_i(brightness_i),
    .is_flush_i  (is_flush_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .q_count_i   (q_count),
    .wr_en_o     (wr_en),
    .wr_col_o    (wr_col),
    .wr_row_o    (wr_row),
    .wr_bit_o    (wr_bit),
    .rd_en_o     (rd_en),
    .rd_col_o    (rd_col),
    .job_valid_o (job_valid),
    .job_meta_o  (job_meta)
  );

  // Ring of mask rows, one bank per window column.
  hcme_line_store #(
    .MAX_WIDTH   (MAX_WIDTH),
    .ERODE_PASSES(ERODE_PASSES)
  ) u_line_store (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_en_i (wr_en),
    .wr_col_i(wr_col),
    .wr_row_i(wr_row),
    .wr_bit_i(wr_bit),
    .rd_en_i (rd_en),
    .rd_col_i(rd_col),
    .words_o (words)
  );

  assign push_entry = '{meta: job_meta, words: words};

  // Queue of pending windows.
  hcme_fifo u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (job_valid),
    .push_data_i(push_entry),
    .pop_i      (pop),
    .pop_data_o (head_entry),
    .count_o    (q_count)
  );

  // Back: window minimum and output register.
  hcme_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .q_count_i     (q_count),
    .entry_i       (head_entry),
    .pop_o         (pop),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .mask_bit_o    (mask_bit_o),
    .end_of_row_o  (end_of_row_o),
    .end_of_frame_o(end_of_frame_o)
  );

  // Positions are recomputed after every geometry write before new input.
  a_cfg_holds_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_we_i |=> !in_ready_o)
    else $error("input accepted while positions were being recomputed");

  // The last word of a frame is always the last word of a row.
  a_eof_is_eor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && end_of_frame_o) |-> end_of_row_o)
    else $error("end of frame without end of row");

  // Credit check: a window leaving the line store always finds queue room.
  a_queue_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    job_valid |-> (q_count < QCNT_W'(QUEUE_DEPTH)))
    else $error("window pushed into a full queue");

endmodule
